FILE: rtl/bdgc_pkg.sv
// Shared types, constants and the click-count decoder for the button gesture classifier.
package bdgc_pkg;

  // Timestamp width; timestamps and elapsed times wrap at this width
  localparam int TIME_BITS = 32;
  localparam int CFG_BITS  = 16;
  localparam int CNT_BITS  = 8;
  localparam int ADDR_BITS = 4;
  localparam int DATA_BITS = 32;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [CFG_BITS-1:0]  cfg_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;

  // Register reset values, in milliseconds
  localparam cfg_t DEBOUNCE_RST     = cfg_t'(30);
  localparam cfg_t CLICK_WINDOW_RST = cfg_t'(350);
  localparam cfg_t HOLD_CONFIRM_RST = cfg_t'(500);
  localparam cfg_t LONG_HOLD_RST    = cfg_t'(2000);

  localparam cnt_t CNT_MAX = {CNT_BITS{1'b1}};

  // Register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_DEBOUNCE     = 2'd0,
    REG_CLICK_WINDOW = 2'd1,
    REG_HOLD_CONFIRM = 2'd2,
    REG_LONG_HOLD    = 2'd3
  } reg_idx_t;

  // Gesture codes
  typedef enum logic [3:0] {
    G_NONE   = 4'd0,
    G_SINGLE = 4'd1,
    G_DOUBLE = 4'd2,
    G_TRIPLE = 4'd3,
    G_FOUR   = 4'd4,
    G_SIX    = 4'd5,
    G_TEN    = 4'd6,
    G_LONG   = 4'd7,
    G_DPH    = 4'd8,
    G_UNCL   = 4'd9
  } gesture_t;

  // Map a finished click count to its gesture
  function automatic gesture_t classify(input cnt_t n);
    gesture_t g;
    case (n)
      cnt_t'(1):  g = G_SINGLE;
      cnt_t'(2):  g = G_DOUBLE;
      cnt_t'(3):  g = G_TRIPLE;
      cnt_t'(4):  g = G_FOUR;
      cnt_t'(6):  g = G_SIX;
      cnt_t'(10): g = G_TEN;
      default:    g = G_UNCL;
    endcase
    return g;
  endfunction

endpackage

FILE: rtl/button_debounce_gesture_classifier_unit.sv
// Top level: debounce, click counting, hold detection and gesture result register.
// A poll's gesture is registered into the result register at the edge that accepts the poll,
// and is shown on the output in the cycle after the accept.
// Throughput: one poll per cycle; the whole state update is one pass of compares and adds.
// A new poll is taken while the result register is empty or is being emptied.
// Reset (rst, synchronous): clears all gesture state, no result pending, registers to defaults.
module button_debounce_gesture_classifier_unit (
  input  logic                          clk,
  input  logic                          rst,
  // poll channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          pressed_raw,
  input  logic [bdgc_pkg::TIME_BITS-1:0] now_ms,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [3:0]                    gesture,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bdgc_pkg::ADDR_BITS-1:0] paddr,
  input  logic [bdgc_pkg::DATA_BITS-1:0] pwdata,
  output logic [bdgc_pkg::DATA_BITS-1:0] prdata,
  output logic                          pready
);

  // Configuration registers
  bdgc_pkg::cfg_t debounce_time, click_window, hold_confirm_time, long_hold_time;

  // Gesture state
  logic            last_raw_level, last_raw_level_next;
  bdgc_pkg::time_t last_change_time, last_change_time_next;
  logic            stable_level, stable_level_next;
  bdgc_pkg::cnt_t  click_count, click_count_next;
  bdgc_pkg::time_t window_deadline, window_deadline_next;
  bdgc_pkg::time_t press_start_time, press_start_time_next;
  logic            hold_reported, hold_reported_next;

  // Result register
  bdgc_pkg::gesture_t result, result_next;

  logic            accept;
  logic            cfg_write;
  bdgc_pkg::reg_idx_t cfg_idx;
  bdgc_pkg::time_t since_change, held;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_idx   = bdgc_pkg::reg_idx_t'(paddr[3:2]);

  // Register write
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_time     <= bdgc_pkg::DEBOUNCE_RST;
      click_window      <= bdgc_pkg::CLICK_WINDOW_RST;
      hold_confirm_time <= bdgc_pkg::HOLD_CONFIRM_RST;
      long_hold_time    <= bdgc_pkg::LONG_HOLD_RST;
    end else if (cfg_write) begin
      unique case (cfg_idx)
        bdgc_pkg::REG_DEBOUNCE:     debounce_time     <= pwdata[bdgc_pkg::CFG_BITS-1:0];
        bdgc_pkg::REG_CLICK_WINDOW: click_window      <= pwdata[bdgc_pkg::CFG_BITS-1:0];
        bdgc_pkg::REG_HOLD_CONFIRM: hold_confirm_time <= pwdata[bdgc_pkg::CFG_BITS-1:0];
        bdgc_pkg::REG_LONG_HOLD:    long_hold_time    <= pwdata[bdgc_pkg::CFG_BITS-1:0];
        default:                    debounce_time     <= debounce_time;
      endcase
    end
  end

  // Register read
  always_comb begin
    unique case (cfg_idx)
      bdgc_pkg::REG_DEBOUNCE:     prdata = bdgc_pkg::DATA_BITS'(debounce_time);
      bdgc_pkg::REG_CLICK_WINDOW: prdata = bdgc_pkg::DATA_BITS'(click_window);
      bdgc_pkg::REG_HOLD_CONFIRM: prdata = bdgc_pkg::DATA_BITS'(hold_confirm_time);
      bdgc_pkg::REG_LONG_HOLD:    prdata = bdgc_pkg::DATA_BITS'(long_hold_time);
      default:                    prdata = '0;
    endcase
  end

  // Handshake: take a request whenever the result register is free or draining
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // One poll: debounce, edge handling, hold check, window expiry
  always_comb begin
    last_raw_level_next   = pressed_raw;
    last_change_time_next = (pressed_raw != last_raw_level) ? now_ms : last_change_time;
    stable_level_next     = stable_level;
    click_count_next      = click_count;
    window_deadline_next  = window_deadline;
    press_start_time_next = press_start_time;
    hold_reported_next    = hold_reported;
    result_next           = bdgc_pkg::G_NONE;

    since_change = now_ms - last_change_time_next;

    // debounced level change
    if (since_change >= bdgc_pkg::TIME_BITS'(debounce_time) &&
        stable_level != last_raw_level_next) begin
      stable_level_next = last_raw_level_next;
      if (last_raw_level_next) begin
        press_start_time_next = now_ms;
        hold_reported_next    = 1'b0;
      end else if (hold_reported) begin
        // release after a hold closes the sequence
        click_count_next     = '0;
        window_deadline_next = '0;
      end else begin
        if (click_count != bdgc_pkg::CNT_MAX) begin
          click_count_next = click_count + bdgc_pkg::cnt_t'(1);
        end
        window_deadline_next = now_ms + bdgc_pkg::TIME_BITS'(click_window);
      end
    end

    held = now_ms - press_start_time_next;

    // hold gesture, once per press
    if (stable_level_next && !hold_reported_next) begin
      if (click_count_next == '0) begin
        if (held >= bdgc_pkg::TIME_BITS'(long_hold_time)) begin
          hold_reported_next = 1'b1;
          result_next        = bdgc_pkg::G_LONG;
        end
      end else if (click_count_next == bdgc_pkg::cnt_t'(1)) begin
        if (held >= bdgc_pkg::TIME_BITS'(hold_confirm_time)) begin
          hold_reported_next = 1'b1;
          result_next        = bdgc_pkg::G_DPH;
        end
      end else begin
        if (held >= bdgc_pkg::TIME_BITS'(hold_confirm_time)) begin
          hold_reported_next = 1'b1;
          result_next        = bdgc_pkg::G_UNCL;
        end
      end
    end

    // click window expiry, only while released, so never in the same poll as a hold
    if (window_deadline_next != '0 && !stable_level_next && now_ms >= window_deadline_next) begin
      result_next          = bdgc_pkg::classify(click_count_next);
      click_count_next     = '0;
      window_deadline_next = '0;
    end
  end

  // State update on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      last_raw_level   <= 1'b0;
      last_change_time <= '0;
      stable_level     <= 1'b0;
      click_count      <= '0;
      window_deadline  <= '0;
      press_start_time <= '0;
      hold_reported    <= 1'b0;
    end else if (accept) begin
      last_raw_level   <= last_raw_level_next;
      last_change_time <= last_change_time_next;
      stable_level     <= stable_level_next;
      click_count      <= click_count_next;
      window_deadline  <= window_deadline_next;
      press_start_time <= press_start_time_next;
      hold_reported    <= hold_reported_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  assign gesture = result;

endmodule

FILE: rtl/bdgc_checker.sv
// Port-level checks for the gesture classifier, bound to the top level.
module bdgc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] gesture
);

  // a held result keeps its value
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(gesture))
    else $error("stalled result changed or vanished");

  // every accepted request yields a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted request gave no result");

  // input is only held back by a full, stalled result register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a pending result");

  // no result straight after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result pending after reset");

  // gesture code within the defined range
  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> gesture <= bdgc_pkg::G_UNCL)
    else $error("gesture code out of range");

endmodule

bind button_debounce_gesture_classifier_unit bdgc_checker u_bdgc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .gesture   (gesture)
);

FILE: sim/testbench.sv
// Self-checking testbench for the button gesture classifier: directed polls, then random click episodes.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLDOFF_CYCLES   = 60;
  localparam int SHOWN_MISMATCHES = 10;
  localparam int PHASE_POLLS      = 35;
  localparam int DIRECTED_ROWS    = 28;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid;
  logic                           in_stall;
  logic                           pressed_raw;
  bdgc_pkg::time_t                now_ms;
  logic                           out_valid;
  logic                           out_stall;
  logic [3:0]                     gesture;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [bdgc_pkg::ADDR_BITS-1:0] paddr;
  logic [bdgc_pkg::DATA_BITS-1:0] pwdata;
  logic [bdgc_pkg::DATA_BITS-1:0] prdata;
  logic                           pready;

  // Directed poll: level, timestamp, and a hand-worked gesture where obvious
  typedef struct packed {
    logic               raw;
    bdgc_pkg::time_t    at;
    logic               fixed;
    bdgc_pkg::gesture_t want;
  } poll_row_t;

  poll_row_t directed_polls [0:DIRECTED_ROWS-1] = '{
    '{1'b0, 32'h0000_0000, 1'b1, bdgc_pkg::G_NONE},    // idle after reset
    // single click
    '{1'b1, 32'd100,       1'b0, bdgc_pkg::G_NONE},
    '{1'b1, 32'd130,       1'b0, bdgc_pkg::G_NONE},
    '{1'b0, 32'd200,       1'b0, bdgc_pkg::G_NONE},
    '{1'b0, 32'd230,       1'b0, bdgc_pkg::G_NONE},
    '{1'b0, 32'd580,       1'b1, bdgc_pkg::G_SINGLE},
    // long hold on the first press, then its release ends the sequence
    '{1'b1, 32'd1000,      1'b0, bdgc_pkg::G_NONE},
    '{1'b1, 32'd1030,      1'b0, bdgc_pkg::G_NONE},
    '{1'b1, 32'd3030,      1'b1, bdgc_pkg::G_LONG},
    '{1'b0, 32'd3200,      1'b0, bdgc_pkg::G_NONE},
    '{1'b0, 32'd3230,      1'b0, bdgc_pkg::G_NONE},
    // click then hold on the second press
    '{1'b1, 32'd5000,      1'b0, bdgc_pkg::G_NONE},
    '{1'b1, 32'd5030,      1'b0, bdgc_pkg::G_NONE},
    '{1'b0, 32'd5100,      1'b0, bdgc_pkg::G_NONE},
    '{1'b0, 32'd5130,      1'b0, bdgc_pkg::G_NONE},
    '{1'b1, 32'd5200,      1'b0, bdgc_pkg::G_NONE},
    '{1'b1, 32'd5230,      1'b0, bdgc_pkg::G_NONE},
    '{1'b1, 32'd5730,      1'b1, bdgc_pkg::G_DPH},
    '{1'b0, 32'd5800,      1'b0, bdgc_pkg::G_NONE},
    '{1'b0, 32'd5830,      1'b0, bdgc_pkg::G_NONE},
    // release whose window end wraps to exactly zero: sequence dropped, count kept
    '{1'b1, 32'hFFFF_FE00, 1'b0, bdgc_pkg::G_NONE},
    '{1'b1, 32'hFFFF_FE1E, 1'b0, bdgc_pkg::G_NONE},
    '{1'b0, 32'hFFFF_FE84, 1'b0, bdgc_pkg::G_NONE},
    '{1'b0, 32'hFFFF_FEA2, 1'b0, bdgc_pkg::G_NONE},
    // window end wraps past zero, so it expires in the same poll
    '{1'b1, 32'hFFFF_FF00, 1'b0, bdgc_pkg::G_NONE},
    '{1'b1, 32'hFFFF_FF1E, 1'b0, bdgc_pkg::G_NONE},
    '{1'b0, 32'hFFFF_FF40, 1'b0, bdgc_pkg::G_NONE},
    '{1'b0, 32'hFFFF_FFFF, 1'b0, bdgc_pkg::G_NONE}
  };

  // Predictor state and its copy of the registers
  logic            seen_raw;
  bdgc_pkg::time_t raw_change_ms;
  logic            debounced;
  bdgc_pkg::cnt_t  clicks;
  bdgc_pkg::time_t window_end_ms;
  bdgc_pkg::time_t press_ms;
  logic            hold_done;
  bdgc_pkg::cfg_t  settle_ms;
  bdgc_pkg::cfg_t  window_ms;
  bdgc_pkg::cfg_t  confirm_ms;
  bdgc_pkg::cfg_t  long_ms;

  bdgc_pkg::gesture_t gesture_due [$];
  bdgc_pkg::gesture_t want_g;
  int unsigned        polls_sent;
  int unsigned        gestures_checked;
  int unsigned        fail_count;
  int unsigned        cfg_writes;
  int unsigned        gesture_hits [0:9];
  bit                 quiet_run;
  bit                 holdoff_req;
  bdgc_pkg::time_t    clock_ms;

  button_debounce_gesture_classifier_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .pressed_raw (pressed_raw),
    .now_ms      (now_ms),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .gesture     (gesture),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Finished click count to gesture code
  function automatic bdgc_pkg::gesture_t count_to_gesture(input bdgc_pkg::cnt_t n);
    case (n)
      bdgc_pkg::cnt_t'(1):  return bdgc_pkg::G_SINGLE;
      bdgc_pkg::cnt_t'(2):  return bdgc_pkg::G_DOUBLE;
      bdgc_pkg::cnt_t'(3):  return bdgc_pkg::G_TRIPLE;
      bdgc_pkg::cnt_t'(4):  return bdgc_pkg::G_FOUR;
      bdgc_pkg::cnt_t'(6):  return bdgc_pkg::G_SIX;
      bdgc_pkg::cnt_t'(10): return bdgc_pkg::G_TEN;
      default:              return bdgc_pkg::G_UNCL;
    endcase
  endfunction

  function automatic void clear_gesture_state();
    seen_raw      = 1'b0;
    raw_change_ms = '0;
    debounced     = 1'b0;
    clicks        = '0;
    window_end_ms = '0;
    press_ms      = '0;
    hold_done     = 1'b0;
    settle_ms     = bdgc_pkg::DEBOUNCE_RST;
    window_ms     = bdgc_pkg::CLICK_WINDOW_RST;
    confirm_ms    = bdgc_pkg::HOLD_CONFIRM_RST;
    long_ms       = bdgc_pkg::LONG_HOLD_RST;
  endfunction

  // One poll through debounce, click counting and hold detection
  function automatic bdgc_pkg::gesture_t classifier_step(input logic raw,
                                                         input bdgc_pkg::time_t at);
    bdgc_pkg::gesture_t g;
    bdgc_pkg::time_t    elapsed;
    g = bdgc_pkg::G_NONE;
    if (raw != seen_raw) begin
      seen_raw      = raw;
      raw_change_ms = at;
    end
    elapsed = at - raw_change_ms;
    if (elapsed >= bdgc_pkg::time_t'(settle_ms) && debounced != seen_raw) begin
      debounced = seen_raw;
      if (debounced) begin
        press_ms  = at;
        hold_done = 1'b0;
      end else if (hold_done) begin
        clicks        = '0;
        window_end_ms = '0;
      end else begin
        if (clicks != bdgc_pkg::CNT_MAX) clicks = clicks + 1'b1;
        window_end_ms = at + bdgc_pkg::time_t'(window_ms);
      end
    end
    // hold: first press uses the long threshold, later presses the confirm one
    if (debounced && !hold_done) begin
      elapsed = at - press_ms;
      if (clicks == 0) begin
        if (elapsed >= bdgc_pkg::time_t'(long_ms)) begin
          hold_done = 1'b1;
          g = bdgc_pkg::G_LONG;
        end
      end else if (elapsed >= bdgc_pkg::time_t'(confirm_ms)) begin
        hold_done = 1'b1;
        g = (clicks == 1) ? bdgc_pkg::G_DPH : bdgc_pkg::G_UNCL;
      end
    end
    // window expiry uses a plain compare, no wrap
    if (window_end_ms != 0 && !debounced && at >= window_end_ms) begin
      g = count_to_gesture(clicks);
      clicks        = '0;
      window_end_ms = '0;
    end
    return g;
  endfunction

  // Offer one poll request and book its expected gesture once taken
  task automatic send_poll(input logic raw, input bdgc_pkg::time_t at,
                           input bit fixed = 1'b0,
                           input bdgc_pkg::gesture_t want = bdgc_pkg::G_NONE);
    bdgc_pkg::gesture_t g;
    if (!quiet_run && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    pressed_raw <= raw;
    now_ms      <= at;
    do @(posedge clk); while (in_stall);
    g = classifier_step(raw, at);
    gesture_due.push_back(fixed ? want : g);
    polls_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (gesture_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Register write, then read back
  task automatic write_reg(input bdgc_pkg::reg_idx_t idx, input bdgc_pkg::cfg_t val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= bdgc_pkg::ADDR_BITS'({idx, 2'b00});
    pwdata  <= bdgc_pkg::DATA_BITS'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== bdgc_pkg::DATA_BITS'(val)) begin
      fail_count++;
      if (fail_count <= SHOWN_MISMATCHES)
        $display("register %s reads %0d, expected %0d", idx.name(), prdata, val);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    case (idx)
      bdgc_pkg::REG_DEBOUNCE:     settle_ms  = val;
      bdgc_pkg::REG_CLICK_WINDOW: window_ms  = val;
      bdgc_pkg::REG_HOLD_CONFIRM: confirm_ms = val;
      bdgc_pkg::REG_LONG_HOLD:    long_ms    = val;
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic apply_setting(input bdgc_pkg::cfg_t db, input bdgc_pkg::cfg_t win,
                               input bdgc_pkg::cfg_t conf, input bdgc_pkg::cfg_t lng);
    drain_results();
    write_reg(bdgc_pkg::REG_DEBOUNCE, db);
    write_reg(bdgc_pkg::REG_CLICK_WINDOW, win);
    write_reg(bdgc_pkg::REG_HOLD_CONFIRM, conf);
    write_reg(bdgc_pkg::REG_LONG_HOLD, lng);
  endtask

  // Hold one level for at least span ms, polled a few times
  task automatic level_run(input logic raw, input int unsigned span);
    int unsigned steps;
    int unsigned stride;
    steps  = $urandom_range(1, 3);
    stride = span / steps + 1;
    clock_ms += 1;
    send_poll(raw, clock_ms);
    repeat (steps) begin
      clock_ms += stride;
      send_poll(raw, clock_ms);
    end
  endtask

  // Contact bounce: short random toggles
  task automatic chatter();
    repeat ($urandom_range(1, 3)) begin
      clock_ms += $urandom_range(1, 3);
      send_poll(1'($urandom_range(0, 1)), clock_ms);
    end
  endtask

  // A click sequence, maybe ending in a hold, then a quiet gap to finish it
  task automatic play_episode();
    int unsigned pick;
    int unsigned presses;
    int unsigned thr;
    int unsigned c;
    bit          hold_last;
    pick = $urandom_range(0, 11);
    if (pick < 6)       presses = pick % 3 + 1;
    else if (pick == 6) presses = 4;
    else if (pick == 7) presses = 6;
    else if (pick == 8) presses = 10;
    else                presses = $urandom_range(1, 12);
    hold_last = ($urandom_range(0, 3) == 0);
    for (c = 0; c < presses; c++) begin
      if ($urandom_range(0, 5) == 0) chatter();
      thr = (c == 0) ? long_ms : confirm_ms;
      if (hold_last && c == presses - 1)
        level_run(1'b1, settle_ms + thr + $urandom_range(0, thr / 4 + 10));
      else
        level_run(1'b1, settle_ms + $urandom_range(0, thr / 2));
      if ($urandom_range(0, 5) == 0) chatter();
      if (c == presses - 1)
        level_run(1'b0, settle_ms + window_ms + $urandom_range(1, 50));
      else
        level_run(1'b0, settle_ms + $urandom_range(0, window_ms / 2));
    end
  endtask

  // Mostly well-formed episodes, some random polls and jumps near the wrap
  task automatic run_phase(input int unsigned budget);
    int unsigned start;
    int unsigned r;
    start = polls_sent;
    while (polls_sent - start < budget) begin
      r = $urandom_range(0, 7);
      if (r == 0) begin
        repeat ($urandom_range(1, 3)) begin
          clock_ms = $urandom();
          send_poll(1'($urandom_range(0, 1)), clock_ms);
        end
      end else if (r == 1) begin
        clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 100000);
      end
      play_episode();
    end
  endtask

  // 256 quick clicks saturate the count, then a held press
  task automatic saturate_clicks();
    repeat (256) begin
      clock_ms += 1;
      send_poll(1'b1, clock_ms);
      clock_ms += 1;
      send_poll(1'b0, clock_ms);
    end
    clock_ms += 1;
    send_poll(1'b1, clock_ms);
    clock_ms += confirm_ms + 1;
    send_poll(1'b1, clock_ms);
    clock_ms += 1;
    send_poll(1'b0, clock_ms);
    clock_ms += window_ms + 1;
    send_poll(1'b0, clock_ms);
  endtask

  // Result checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (gesture_due.size() == 0) begin
        fail_count++;
        if (fail_count <= SHOWN_MISMATCHES)
          $display("unexpected gesture %0d at %0t", gesture, $time);
      end else begin
        want_g = gesture_due.pop_front();
        gestures_checked++;
        if (gesture !== want_g) begin
          fail_count++;
          if (fail_count <= SHOWN_MISMATCHES)
            $display("gesture mismatch at %0t: got %0d, expected %0d (%s)",
                     $time, gesture, want_g, want_g.name());
        end else begin
          gesture_hits[want_g]++;
        end
      end
    end
  end

  // Receiver stalls: random bursts, one long hold-off on request, none at the end
  initial begin
    out_stall = 1'b0;
    forever begin
      if (quiet_run) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else if (holdoff_req) begin
        out_stall <= 1'b1;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
        holdoff_req = 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("testbench: timed out");
    $display("testbench: done, errors");
    $finish;
  end

  initial begin
    int unsigned i;
    in_valid    = 1'b0;
    pressed_raw = 1'b0;
    now_ms      = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    quiet_run   = 1'b0;
    holdoff_req = 1'b0;
    clock_ms    = '0;
    polls_sent  = 0;
    gestures_checked = 0;
    fail_count  = 0;
    cfg_writes  = 0;
    for (i = 0; i < 10; i++) gesture_hits[i] = 0;
    clear_gesture_state();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed table, reset register values
    for (i = 0; i < DIRECTED_ROWS; i++)
      send_poll(directed_polls[i].raw, directed_polls[i].at, directed_polls[i].fixed,
                directed_polls[i].want);
    clock_ms = 32'hFFFF_FFFF;

    // defaults, with a long receiver hold-off while polls keep coming
    holdoff_req = 1'b1;
    run_phase(PHASE_POLLS);

    // no debounce: count saturation
    apply_setting(16'd0, 16'd350, 16'd500, 16'd2000);
    saturate_clicks();
    run_phase(PHASE_POLLS);

    // extremes
    apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_phase(PHASE_POLLS);
    apply_setting(16'd0, 16'd0, 16'd0, 16'd0);
    run_phase(PHASE_POLLS);

    // moderate random and full-range random settings
    apply_setting(bdgc_pkg::cfg_t'($urandom_range(1, 60)),
                  bdgc_pkg::cfg_t'($urandom_range(20, 800)),
                  bdgc_pkg::cfg_t'($urandom_range(50, 1000)),
                  bdgc_pkg::cfg_t'($urandom_range(100, 3000)));
    run_phase(PHASE_POLLS);
    apply_setting(bdgc_pkg::cfg_t'($urandom_range(0, 65535)),
                  bdgc_pkg::cfg_t'($urandom_range(0, 65535)),
                  bdgc_pkg::cfg_t'($urandom_range(0, 65535)),
                  bdgc_pkg::cfg_t'($urandom_range(0, 65535)));
    run_phase(PHASE_POLLS);

    // last stretch without idling on either side
    apply_setting(16'd5, 16'd120, 16'd200, 16'd400);
    quiet_run = 1'b1;
    run_phase(PHASE_POLLS);
    drain_results();

    $display("testbench: %0d polls, %0d gestures checked, %0d register writes, 7 settings",
             polls_sent, gestures_checked, cfg_writes);
    $display("testbench: gestures by code 0-9: %0d %0d %0d %0d %0d %0d %0d %0d %0d %0d",
             gesture_hits[0], gesture_hits[1], gesture_hits[2], gesture_hits[3],
             gesture_hits[4], gesture_hits[5], gesture_hits[6], gesture_hits[7],
             gesture_hits[8], gesture_hits[9]);
    if (fail_count == 0 && gesture_due.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

FILE: button_debounce_gesture_classifier_unit.f
rtl/bdgc_pkg.sv
rtl/button_debounce_gesture_classifier_unit.sv
rtl/bdgc_checker.sv
sim/testbench.sv
